// ===== hdl/qpvt_pkg.sv =====
// shared types and constants for the quaternion pose vector transform
// no dependencies; every design file but qpvt_checker refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package qpvt_pkg;

    localparam int VEC_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ENT_W      = 35;
    localparam int PROD_W     = 67;
    localparam int ACC_W      = 72;
    localparam int FRAC_ROT   = 28;
    localparam int FRAC_W     = 16;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [ENT_W-1:0]  ent_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam ent_t ONE_Q28 = ENT_W'(32'sd268435456);
    localparam acc_t SAT_MAX = ACC_W'(32'sh7fffffff);
    localparam acc_t SAT_MIN = ~SAT_MAX;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X  = 3'd0,
        REG_QUAT_Y  = 3'd1,
        REG_QUAT_Z  = 3'd2,
        REG_QUAT_W  = 3'd3,
        REG_TRANS_X = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_TRANS_Z = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        vec_t z;
        vec_t w;
        logic is_dir;
    } vec_item_t;

    typedef struct packed {
        ent_t [2:0][2:0] rot;
        vec_t [2:0]      trans;
    } mat_t;

endpackage

`default_nettype wire

// ===== hdl/qpvt_matrix.sv =====
// configuration registers and the registered 3x3 rotation and translation of the transform
// depends on qpvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qpvt_matrix (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    input  wire  [qpvt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [qpvt_pkg::CFG_DATA_W-1:0]       cfg_data,
    output qpvt_pkg::mat_t                        mat
);

    qpvt_pkg::quat_t qx_reg;
    qpvt_pkg::quat_t qy_reg;
    qpvt_pkg::quat_t qz_reg;
    qpvt_pkg::quat_t qw_reg;
    qpvt_pkg::vec_t  tx_reg;
    qpvt_pkg::vec_t  ty_reg;
    qpvt_pkg::vec_t  tz_reg;

    qpvt_pkg::mat_t  mat_reg;
    qpvt_pkg::mat_t  mat_next;

    logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_xw, p_yw, p_zw;
    logic signed [32:0] t_xx, t_yy, t_zz, t_xy, t_xz, t_yz, t_xw, t_yw, t_zw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= 16'sd16384;
            tx_reg <= '0;
            ty_reg <= '0;
            tz_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (qpvt_pkg::cfg_reg_t'(cfg_index))
                qpvt_pkg::REG_QUAT_X:  qx_reg <= cfg_data[qpvt_pkg::QUAT_W-1:0];
                qpvt_pkg::REG_QUAT_Y:  qy_reg <= cfg_data[qpvt_pkg::QUAT_W-1:0];
                qpvt_pkg::REG_QUAT_Z:  qz_reg <= cfg_data[qpvt_pkg::QUAT_W-1:0];
                qpvt_pkg::REG_QUAT_W:  qw_reg <= cfg_data[qpvt_pkg::QUAT_W-1:0];
                qpvt_pkg::REG_TRANS_X: tx_reg <= cfg_data;
                qpvt_pkg::REG_TRANS_Y: ty_reg <= cfg_data;
                qpvt_pkg::REG_TRANS_Z: tz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // quaternion products, doubled
    assign p_xx = qx_reg * qx_reg;
    assign p_yy = qy_reg * qy_reg;
    assign p_zz = qz_reg * qz_reg;
    assign p_xy = qx_reg * qy_reg;
    assign p_xz = qx_reg * qz_reg;
    assign p_yz = qy_reg * qz_reg;
    assign p_xw = qx_reg * qw_reg;
    assign p_yw = qy_reg * qw_reg;
    assign p_zw = qz_reg * qw_reg;

    assign t_xx = {p_xx, 1'b0};
    assign t_yy = {p_yy, 1'b0};
    assign t_zz = {p_zz, 1'b0};
    assign t_xy = {p_xy, 1'b0};
    assign t_xz = {p_xz, 1'b0};
    assign t_yz = {p_yz, 1'b0};
    assign t_xw = {p_xw, 1'b0};
    assign t_yw = {p_yw, 1'b0};
    assign t_zw = {p_zw, 1'b0};

    always_comb
    begin
        mat_next.rot[0][0] = qpvt_pkg::ONE_Q28 - qpvt_pkg::ENT_W'(t_yy)
                             - qpvt_pkg::ENT_W'(t_zz);
        mat_next.rot[0][1] = qpvt_pkg::ENT_W'(t_xy) + qpvt_pkg::ENT_W'(t_zw);
        mat_next.rot[0][2] = qpvt_pkg::ENT_W'(t_xz) - qpvt_pkg::ENT_W'(t_yw);
        mat_next.rot[1][0] = qpvt_pkg::ENT_W'(t_xy) - qpvt_pkg::ENT_W'(t_zw);
        mat_next.rot[1][1] = qpvt_pkg::ONE_Q28 - qpvt_pkg::ENT_W'(t_xx)
                             - qpvt_pkg::ENT_W'(t_zz);
        mat_next.rot[1][2] = qpvt_pkg::ENT_W'(t_yz) + qpvt_pkg::ENT_W'(t_xw);
        mat_next.rot[2][0] = qpvt_pkg::ENT_W'(t_xz) + qpvt_pkg::ENT_W'(t_yw);
        mat_next.rot[2][1] = qpvt_pkg::ENT_W'(t_yz) - qpvt_pkg::ENT_W'(t_xw);
        mat_next.rot[2][2] = qpvt_pkg::ONE_Q28 - qpvt_pkg::ENT_W'(t_xx)
                             - qpvt_pkg::ENT_W'(t_yy);
        mat_next.trans[0]  = tx_reg;
        mat_next.trans[1]  = ty_reg;
        mat_next.trans[2]  = tz_reg;
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

// ===== hdl/qpvt_front.sv =====
// front end: takes input beats, marks direction vectors, queues them
// depends on qpvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module qpvt_front #(
    parameter int DEPTH = 2
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire  qpvt_pkg::vec_t     vec_x,
    input  wire  qpvt_pkg::vec_t     vec_y,
    input  wire  qpvt_pkg::vec_t     vec_z,
    input  wire  qpvt_pkg::vec_t     vec_w,
    output logic                     pop,
    output qpvt_pkg::vec_item_t      item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qpvt_pkg::vec_item_t q_reg [DEPTH];
    qpvt_pkg::vec_item_t in_item;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             push;

    assign push = start && !busy_reg;
    assign pop  = (count_reg != '0);

    always_comb
    begin
        in_item.x      = vec_x;
        in_item.y      = vec_y;
        in_item.z      = vec_z;
        in_item.w      = vec_w;
        in_item.is_dir = (vec_w == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        busy_next = (count_next == CNT_W'(DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            busy_reg   <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign item = q_reg[rd_ptr_reg];
    assign busy = busy_reg;

endmodule

`default_nettype wire

// ===== hdl/qpvt_back.sv =====
// back end: product stage, row sum stage, round and saturate stage
// depends on qpvt_pkg; takes the matrix from qpvt_matrix
`timescale 1ns / 1ps
`default_nettype none

module qpvt_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      pop,
    input  wire  qpvt_pkg::vec_item_t item,
    input  wire  qpvt_pkg::mat_t     mat,
    output logic                     done,
    output qpvt_pkg::vec_t           out_x,
    output qpvt_pkg::vec_t           out_y,
    output qpvt_pkg::vec_t           out_z,
    output qpvt_pkg::vec_t           out_w,
    output logic                     saturated
);

    function automatic logic [qpvt_pkg::VEC_W:0] round_sat(
        input qpvt_pkg::acc_t acc,
        input int             frac
    );
        qpvt_pkg::acc_t              rounded;
        qpvt_pkg::acc_t              shifted;
        logic [qpvt_pkg::VEC_W:0]    res;
        rounded = acc + (qpvt_pkg::ACC_W'(1) << (frac - 1));
        shifted = rounded >>> frac;
        if (shifted > qpvt_pkg::SAT_MAX)
        begin
            res = {1'b1, qpvt_pkg::SAT_MAX[qpvt_pkg::VEC_W-1:0]};
        end
        else if (shifted < qpvt_pkg::SAT_MIN)
        begin
            res = {1'b1, qpvt_pkg::SAT_MIN[qpvt_pkg::VEC_W-1:0]};
        end
        else
        begin
            res = {1'b0, shifted[qpvt_pkg::VEC_W-1:0]};
        end
        return res;
    endfunction

    logic signed [qpvt_pkg::PROD_W-1:0] prod_reg  [4][4];
    logic signed [qpvt_pkg::PROD_W-1:0] prod_next [4][4];
    qpvt_pkg::acc_t                     sum_reg   [4];
    qpvt_pkg::acc_t                     sum_next  [4];
    qpvt_pkg::vec_t                     vin       [3];
    logic [qpvt_pkg::VEC_W:0]           res       [4];

    logic           prod_vld_reg;
    logic           sum_vld_reg;
    logic           done_reg;
    qpvt_pkg::vec_t out_reg [4];
    logic           sat_reg;

    assign vin[0] = item.x;
    assign vin[1] = item.y;
    assign vin[2] = item.z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = qpvt_pkg::ent_t'(mat.rot[r][c]) * vin[c];
            end
            prod_next[r][3] = '0;
        end
        for (int c = 0; c < 3; c++)
        begin
            prod_next[3][c] = qpvt_pkg::vec_t'(mat.trans[c]) * vin[c];
        end
        // points carry vec_w scaled to the translation's fraction
        prod_next[3][3] = item.is_dir ? '0
                        : qpvt_pkg::PROD_W'(item.w) <<< qpvt_pkg::FRAC_W;
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = qpvt_pkg::ACC_W'(prod_reg[r][0])
                        + qpvt_pkg::ACC_W'(prod_reg[r][1])
                        + qpvt_pkg::ACC_W'(prod_reg[r][2])
                        + qpvt_pkg::ACC_W'(prod_reg[r][3]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            res[r] = round_sat(sum_reg[r], qpvt_pkg::FRAC_ROT);
        end
        res[3] = round_sat(sum_reg[3], qpvt_pkg::FRAC_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= pop;
            sum_vld_reg  <= prod_vld_reg;
            done_reg     <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        for (int r = 0; r < 4; r++)
        begin
            out_reg[r] <= res[r][qpvt_pkg::VEC_W-1:0];
        end
        sat_reg <= res[0][qpvt_pkg::VEC_W] | res[1][qpvt_pkg::VEC_W]
                 | res[2][qpvt_pkg::VEC_W] | res[3][qpvt_pkg::VEC_W];
    end

    assign done      = done_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign out_w     = out_reg[3];
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ===== hdl/quaternion_pose_vector_transform_top.sv =====
// a taken vector passes the queue, product and row sum registers to its result with done
// one vector per cycle unless busy; a nonempty queue pops into a three-stage back end
// busy is high during reset and for one cycle after it; the front queue holds two beats
// reset clears the queue and pipeline valids; registers return to the identity pose
// top level: front queue, matrix builder and back-end datapath
// depends on qpvt_pkg, qpvt_front, qpvt_matrix, qpvt_back
`timescale 1ns / 1ps
`default_nettype none

module quaternion_pose_vector_transform_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  qpvt_pkg::vec_t                  vec_x,
    input  wire  qpvt_pkg::vec_t                  vec_y,
    input  wire  qpvt_pkg::vec_t                  vec_z,
    input  wire  qpvt_pkg::vec_t                  vec_w,
    output logic                                  done,
    output qpvt_pkg::vec_t                        out_x,
    output qpvt_pkg::vec_t                        out_y,
    output qpvt_pkg::vec_t                        out_z,
    output qpvt_pkg::vec_t                        out_w,
    output logic                                  saturated,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [qpvt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [qpvt_pkg::CFG_DATA_W-1:0]       cfg_data
);

    qpvt_pkg::vec_item_t item;
    qpvt_pkg::mat_t      mat;
    logic                pop;
    logic                cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    qpvt_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .vec_x (vec_x),
        .vec_y (vec_y),
        .vec_z (vec_z),
        .vec_w (vec_w),
        .pop   (pop),
        .item  (item)
    );

    qpvt_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    qpvt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .item      (item),
        .mat       (mat),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

// ===== hdl/qpvt_checker.sv =====
// port-level checks for the transform top level, attached by bind
// depends on quaternion_pose_vector_transform_top's ports only
`timescale 1ns / 1ps
`default_nettype none

module qpvt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [31:0] out_x,
    input wire [31:0] out_y,
    input wire [31:0] out_z,
    input wire [31:0] out_w,
    input wire        saturated
);

    logic acc_beat;
    logic clip_x, clip_y, clip_z, clip_w;

    assign acc_beat = start && !busy;
    assign clip_x   = (out_x == 32'h7fffffff) || (out_x == 32'h80000000);
    assign clip_y   = (out_y == 32'h7fffffff) || (out_y == 32'h80000000);
    assign clip_z   = (out_z == 32'h7fffffff) || (out_z == 32'h80000000);
    assign clip_w   = (out_w == 32'h7fffffff) || (out_w == 32'h80000000);

    // every accepted beat yields a result once it has passed the queue and the product, row sum and output registers
    a_beat_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc_beat |-> ##4 done)
        else $error("accepted beat gave no result");

    // no result without an accepted beat that entered the pipeline ahead of it
    a_done_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(acc_beat, 4))
        else $error("result without accepted beat");

    // saturation flag only with a clipped component
    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (clip_x || clip_y || clip_z || clip_w))
        else $error("saturated set with no clipped output");

    // busy only rises after a beat fills the queue
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(acc_beat))
        else $error("busy rose without an accepted beat");

endmodule

bind quaternion_pose_vector_transform_top qpvt_checker u_qpvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
);

`default_nettype wire
